FILE: hdl/assert_macros.svh
// Assertion macros for the top-level RTL file of the wheel velocity PID controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante.
`define WV_ASSERT_IMPL(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("wvpc assertion failed");

// Check that cons holds in the cycle after ante.
`define WV_ASSERT_NEXT(label, ck, rn, ante, cons) \
    label: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("wvpc assertion failed");

`else

`define WV_ASSERT_IMPL(label, ck, rn, ante, cons)
`define WV_ASSERT_NEXT(label, ck, rn, ante, cons)

`endif

`endif

FILE: hdl/wvpc_pkg.sv
// Shared types, constants and command codes of the wheel velocity PID controller.
`default_nettype none

package wvpc_pkg;

    // Field widths
    localparam int COUNT_WIDTH = 32;
    localparam int POS_W       = 48;
    localparam int TGT_W       = 64;
    localparam int MAG_W       = 57;
    localparam int TERM_W      = 48;
    localparam int INTEG_W     = 17;
    localparam int LIMIT_W     = 15;
    localparam int GAIN_W      = 32;
    localparam int TV_W        = 32;
    localparam int SD_W        = 24;
    localparam int DUTY_W      = 16;
    localparam int IN_DATA_W   = 88;
    localparam int OUT_DATA_W  = 72;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // Fixed-point shifts of the gain products
    localparam int SHIFT_TGT  = 16;
    localparam int SHIFT_DUTY = 17;

    // Saturation bound of every gain product
    localparam logic [TERM_W-2:0] TERM_LIMIT = '1;

    // Stop threshold on target velocity, raw Q16.16
    localparam logic signed [TV_W-1:0] IDLE_VEL_RAW = 32'sd6;

    // Input opcodes
    localparam logic OPC_SENSOR = 1'b0;
    localparam logic OPC_TICK   = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_GAIN  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_VEL_PER_STEP = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_VEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INTEG_CLAMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT  = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANTIWINDUP  = 3'd7;

    // Gain product selectors
    localparam logic [1:0] TERM_TV = 2'd0;
    localparam logic [1:0] TERM_KP = 2'd1;
    localparam logic [1:0] TERM_KI = 2'd2;
    localparam logic [1:0] TERM_KD = 2'd3;

    // Datapath operations
    localparam int OP_W = 4;
    localparam logic [OP_W-1:0] OP_NONE      = 4'd0;
    localparam logic [OP_W-1:0] OP_CAPTURE   = 4'd1;
    localparam logic [OP_W-1:0] OP_SENSOR    = 4'd2;
    localparam logic [OP_W-1:0] OP_IDLE_TICK = 4'd3;
    localparam logic [OP_W-1:0] OP_TERM_LOAD = 4'd4;
    localparam logic [OP_W-1:0] OP_MUL_LO    = 4'd5;
    localparam logic [OP_W-1:0] OP_MUL_HI    = 4'd6;
    localparam logic [OP_W-1:0] OP_TERM_FIN  = 4'd7;
    localparam logic [OP_W-1:0] OP_TGT_ADD   = 4'd8;
    localparam logic [OP_W-1:0] OP_ERR       = 4'd9;
    localparam logic [OP_W-1:0] OP_TGT_FIX   = 4'd10;
    localparam logic [OP_W-1:0] OP_VEL_MUL   = 4'd11;
    localparam logic [OP_W-1:0] OP_VEL_DIFF  = 4'd12;
    localparam logic [OP_W-1:0] OP_INTEG     = 4'd13;
    localparam logic [OP_W-1:0] OP_SUM       = 4'd14;

    // Controller to datapath command
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic [1:0]      term;
        logic            seed;
        logic            out_load;
    } dp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic tv_small;
    } dp_stat_t;

endpackage

`default_nettype wire

FILE: hdl/wvpc_ctrl.sv
// Sequencing state machine of the wheel velocity PID controller.
`default_nettype none

module wvpc_ctrl
    import wvpc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  logic     opcode,
    output logic     m_tvalid,
    input  logic     m_tready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    localparam logic [3:0] ST_IDLE      = 4'd0;
    localparam logic [3:0] ST_SENSOR    = 4'd1;
    localparam logic [3:0] ST_IDLE_TICK = 4'd2;
    localparam logic [3:0] ST_T_LOAD    = 4'd3;
    localparam logic [3:0] ST_T_LO      = 4'd4;
    localparam logic [3:0] ST_T_HI      = 4'd5;
    localparam logic [3:0] ST_T_FIN     = 4'd6;
    localparam logic [3:0] ST_TGT_ADD   = 4'd7;
    localparam logic [3:0] ST_ERR       = 4'd8;
    localparam logic [3:0] ST_TGT_FIX   = 4'd9;
    localparam logic [3:0] ST_VEL_MUL   = 4'd10;
    localparam logic [3:0] ST_VEL_DIFF  = 4'd11;
    localparam logic [3:0] ST_INTEG     = 4'd12;
    localparam logic [3:0] ST_SUM       = 4'd13;
    localparam logic [3:0] ST_EMIT      = 4'd14;

    logic [3:0] state_reg, state_next;
    logic [1:0] term_reg, term_next;
    logic       pending_reg, pending_next;
    logic       idle_reg, idle_next;
    logic       valid_reg, valid_next;
    logic       slot_free;

    assign slot_free = !valid_reg || m_tready;
    assign m_tvalid  = valid_reg;

    // Advance the sequence and issue one datapath operation a cycle, none while ST_EMIT waits
    always_comb
    begin
        state_next   = state_reg;
        term_next    = term_reg;
        pending_next = pending_reg;
        idle_next    = idle_reg;
        s_tready     = 1'b0;
        cmd.op       = OP_NONE;
        cmd.term     = term_reg;
        cmd.seed     = pending_reg;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op = OP_CAPTURE;
                    if (opcode == OPC_SENSOR)
                    begin
                        state_next = ST_SENSOR;
                    end
                    else if (idle_reg)
                    begin
                        state_next = ST_IDLE_TICK;
                    end
                    else
                    begin
                        term_next  = TERM_TV;
                        state_next = ST_T_LOAD;
                    end
                end
            end
            ST_SENSOR:
            begin
                cmd.op       = OP_SENSOR;
                pending_next = 1'b0;
                state_next   = ST_EMIT;
            end
            ST_IDLE_TICK:
            begin
                cmd.op = OP_IDLE_TICK;
                if (!pending_reg)
                begin
                    idle_next = 1'b0;
                end
                state_next = ST_EMIT;
            end
            ST_T_LOAD:
            begin
                cmd.op     = OP_TERM_LOAD;
                state_next = ST_T_LO;
            end
            ST_T_LO:
            begin
                cmd.op     = OP_MUL_LO;
                state_next = ST_T_HI;
            end
            ST_T_HI:
            begin
                cmd.op     = OP_MUL_HI;
                state_next = ST_T_FIN;
            end
            ST_T_FIN:
            begin
                cmd.op = OP_TERM_FIN;
                case (term_reg)
                    TERM_TV: state_next = ST_TGT_ADD;
                    TERM_KP:
                    begin
                        term_next  = TERM_KI;
                        state_next = ST_T_LOAD;
                    end
                    TERM_KI: state_next = ST_VEL_MUL;
                    default: state_next = ST_INTEG;
                endcase
            end
            ST_TGT_ADD:
            begin
                cmd.op     = OP_TGT_ADD;
                state_next = ST_ERR;
            end
            ST_ERR:
            begin
                cmd.op     = OP_ERR;
                state_next = ST_TGT_FIX;
            end
            ST_TGT_FIX:
            begin
                cmd.op     = OP_TGT_FIX;
                term_next  = TERM_KP;
                state_next = ST_T_LOAD;
            end
            ST_VEL_MUL:
            begin
                cmd.op     = OP_VEL_MUL;
                state_next = ST_VEL_DIFF;
            end
            ST_VEL_DIFF:
            begin
                cmd.op     = OP_VEL_DIFF;
                term_next  = TERM_KD;
                state_next = ST_T_LOAD;
            end
            ST_INTEG:
            begin
                cmd.op     = OP_INTEG;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.op     = OP_SUM;
                idle_next  = stat.tv_small;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hold the result until the output register is free
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Output word valid: set on load, drop once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.out_load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            term_reg    <= TERM_TV;
            pending_reg <= 1'b1;
            idle_reg    <= 1'b1;
            valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            term_reg    <= term_next;
            pending_reg <= pending_next;
            idle_reg    <= idle_next;
            valid_reg   <= valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wvpc_dp.sv
// Datapath of the wheel velocity PID controller: registers, shared multiplier, adders.
`default_nettype none

module wvpc_dp
    import wvpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  dp_cmd_t               cmd,
    output dp_stat_t              stat,
    output logic [OUT_DATA_W-1:0] m_tdata
);

    // Configuration registers
    logic [GAIN_W-1:0]  kp_reg, kp_next;
    logic [GAIN_W-1:0]  ki_reg, ki_next;
    logic [GAIN_W-1:0]  kd_reg, kd_next;
    logic [GAIN_W-1:0]  vps_reg, vps_next;
    logic [GAIN_W-1:0]  spv_reg, spv_next;
    logic [LIMIT_W-1:0] iclamp_reg, iclamp_next;
    logic [LIMIT_W-1:0] dlimit_reg, dlimit_next;
    logic               aw_reg, aw_next;

    // Controller state
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [COUNT_WIDTH-1:0] prev_reg, prev_next;
    logic [TGT_W-1:0]       target_reg, target_next;
    logic [INTEG_W-1:0]     integ_reg, integ_next;

    // Working registers
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [TV_W-1:0]        tv_reg;
    logic [SD_W-1:0]        sd_reg;
    logic [TERM_W-1:0]      e_reg;
    logic [MAG_W-1:0]       ed_reg;
    logic [MAG_W-1:0]       mag_reg;
    logic                   neg_reg;
    logic [63:0]            mul_reg;
    logic [63:0]            plo_reg;
    logic [TERM_W-1:0]      tterm_reg;
    logic [TERM_W-1:0]      up_reg;
    logic [TERM_W-1:0]      ui_reg;
    logic [TERM_W-1:0]      ud_reg;
    logic [TERM_W:0]        pd_reg;
    logic [DUTY_W-1:0]      duty_res_reg;
    logic                   active_res_reg;
    logic [OUT_DATA_W-1:0]  out_reg;

    // Combinational signals
    logic [COUNT_WIDTH-1:0] cnt_base, cnt_delta;
    logic [MAG_W-1:0]       src_val, src_mag;
    logic [GAIN_W-1:0]      gain_sel;
    logic [31:0]            mul_a, mul_b;
    logic [63:0]            mul_prod;
    logic [SD_W-1:0]        sd_mag;
    logic [95:0]            p_full, p_shift;
    logic                   p_sat;
    logic [TERM_W-2:0]      q_mag;
    logic [TERM_W-1:0]      term_val;
    logic [55:0]            vel_prod;
    logic [MAG_W-1:0]       ed_val;
    logic signed [TERM_W:0] isum, iclamp, iclamp_neg;
    logic signed [TERM_W+1:0] pd_ext, integ_ext, u_val, lim, lim_neg, t_pos, t_neg;
    logic [DUTY_W-1:0]      duty_val;

    assign stat.tv_small = ($signed(tv_reg) >= -IDLE_VEL_RAW) &&
                           ($signed(tv_reg) <= IDLE_VEL_RAW);
    assign m_tdata = out_reg;

    // Sensor count difference, wrapped to the counter width
    assign cnt_base  = cmd.seed ? cnt_reg : prev_reg;
    assign cnt_delta = cnt_reg - cnt_base;

    // Operand of the current gain product and its magnitude
    always_comb
    begin
        case (cmd.term)
            TERM_TV: src_val = {{(MAG_W-TV_W){tv_reg[TV_W-1]}}, tv_reg};
            TERM_KP: src_val = {{(MAG_W-TERM_W){e_reg[TERM_W-1]}}, e_reg};
            TERM_KI: src_val = {{(MAG_W-TERM_W){e_reg[TERM_W-1]}}, e_reg};
            default: src_val = ed_reg;
        endcase
        case (cmd.term)
            TERM_TV: gain_sel = spv_reg;
            TERM_KP: gain_sel = kp_reg;
            TERM_KI: gain_sel = ki_reg;
            default: gain_sel = kd_reg;
        endcase
    end
    assign src_mag = src_val[MAG_W-1] ? ({MAG_W{1'b0}} - src_val) : src_val;
    assign sd_mag  = sd_reg[SD_W-1] ? ({SD_W{1'b0}} - sd_reg) : sd_reg;

    // Shared 32x32 multiplier operands
    always_comb
    begin
        case (cmd.op)
            OP_MUL_HI:  mul_a = {{(64-MAG_W){1'b0}}, mag_reg[MAG_W-1:32]};
            OP_VEL_MUL: mul_a = {{(32-SD_W){1'b0}}, sd_mag};
            default:    mul_a = mag_reg[31:0];
        endcase
        mul_b = (cmd.op == OP_VEL_MUL) ? vps_reg : gain_sel;
    end
    assign mul_prod = {32'd0, mul_a} * {32'd0, mul_b};

    // Join partial products, shift, saturate and restore sign
    assign p_full   = {mul_reg, 32'd0} + {32'd0, plo_reg};
    assign p_shift  = (cmd.term == TERM_TV) ? (p_full >> SHIFT_TGT) : (p_full >> SHIFT_DUTY);
    assign p_sat    = |p_shift[95:TERM_W-1];
    assign q_mag    = p_sat ? TERM_LIMIT : p_shift[TERM_W-2:0];
    assign term_val = neg_reg ? ({TERM_W{1'b0}} - {1'b0, q_mag}) : {1'b0, q_mag};

    // Velocity error: target velocity minus measured velocity
    assign vel_prod = mul_reg[55:0];
    assign ed_val   = {{(MAG_W-TV_W){tv_reg[TV_W-1]}}, tv_reg} +
                      (sd_reg[SD_W-1] ? {1'b0, vel_prod} : ({MAG_W{1'b0}} - {1'b0, vel_prod}));

    // Integrator sum and its clamp
    assign isum       = $signed({{(TERM_W+1-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg}) +
                        $signed({ui_reg[TERM_W-1], ui_reg});
    assign iclamp     = $signed({{(TERM_W+1-LIMIT_W){1'b0}}, iclamp_reg});
    assign iclamp_neg = -iclamp;

    // Final sum, duty clamp and back-calculation bounds
    assign pd_ext    = $signed({pd_reg[TERM_W], pd_reg});
    assign integ_ext = $signed({{(TERM_W+2-INTEG_W){integ_reg[INTEG_W-1]}}, integ_reg});
    assign u_val     = pd_ext + integ_ext;
    assign lim       = $signed({{(TERM_W+2-LIMIT_W){1'b0}}, dlimit_reg});
    assign lim_neg   = -lim;
    assign t_pos     = lim - pd_ext;
    assign t_neg     = lim_neg - pd_ext;

    always_comb
    begin
        if (u_val > lim)
        begin
            duty_val = lim[DUTY_W-1:0];
        end
        else if (u_val < lim_neg)
        begin
            duty_val = lim_neg[DUTY_W-1:0];
        end
        else
        begin
            duty_val = u_val[DUTY_W-1:0];
        end
    end

    // Next values of configuration and state
    always_comb
    begin
        kp_next     = kp_reg;
        ki_next     = ki_reg;
        kd_next     = kd_reg;
        vps_next    = vps_reg;
        spv_next    = spv_reg;
        iclamp_next = iclamp_reg;
        dlimit_next = dlimit_reg;
        aw_next     = aw_reg;
        pos_next    = pos_reg;
        prev_next   = prev_reg;
        target_next = target_reg;
        integ_next  = integ_reg;

        if (cfg_we)
        begin
            case (cfg_index)
                REG_PROP_GAIN:     kp_next     = cfg_data;
                REG_INTEG_GAIN:    ki_next     = cfg_data;
                REG_DERIV_GAIN:    kd_next     = cfg_data;
                REG_VEL_PER_STEP:  vps_next    = cfg_data;
                REG_STEPS_PER_VEL: spv_next    = cfg_data;
                REG_INTEG_CLAMP:   iclamp_next = cfg_data[LIMIT_W-1:0];
                REG_DUTY_LIMIT:    dlimit_next = cfg_data[LIMIT_W-1:0];
                REG_ANTIWINDUP:    aw_next     = cfg_data[0];
                default:           aw_next     = aw_reg;
            endcase
        end

        case (cmd.op)
            OP_SENSOR:
            begin
                pos_next  = pos_reg +
                            {{(POS_W-COUNT_WIDTH){cnt_delta[COUNT_WIDTH-1]}}, cnt_delta};
                prev_next = cnt_reg;
            end
            OP_IDLE_TICK:
            begin
                target_next = {pos_reg, 16'd0};
                integ_next  = '0;
            end
            OP_TGT_ADD:
            begin
                target_next = target_reg +
                              {{(TGT_W-TERM_W){tterm_reg[TERM_W-1]}}, tterm_reg};
            end
            OP_TGT_FIX:
            begin
                target_next = {pos_reg, 16'd0} + {{(TGT_W-TERM_W){e_reg[TERM_W-1]}}, e_reg};
            end
            OP_INTEG:
            begin
                if (isum > iclamp)
                begin
                    integ_next = iclamp[INTEG_W-1:0];
                end
                else if (isum < iclamp_neg)
                begin
                    integ_next = iclamp_neg[INTEG_W-1:0];
                end
                else
                begin
                    integ_next = isum[INTEG_W-1:0];
                end
            end
            OP_SUM:
            begin
                // Pull the integrator back so the sum sits on the duty limit
                if (aw_reg && (u_val > lim) && (integ_ext > 0))
                begin
                    integ_next = (t_pos > 0) ? t_pos[INTEG_W-1:0] : '0;
                end
                else if (aw_reg && (u_val < lim_neg) && (integ_ext < 0))
                begin
                    integ_next = (t_neg < 0) ? t_neg[INTEG_W-1:0] : '0;
                end
            end
            default: integ_next = integ_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg     <= '0;
            ki_reg     <= '0;
            kd_reg     <= '0;
            vps_reg    <= '0;
            spv_reg    <= '0;
            iclamp_reg <= '1;
            dlimit_reg <= '1;
            aw_reg     <= 1'b0;
            pos_reg    <= '0;
            prev_reg   <= '0;
            target_reg <= '0;
            integ_reg  <= '0;
        end
        else
        begin
            kp_reg     <= kp_next;
            ki_reg     <= ki_next;
            kd_reg     <= kd_next;
            vps_reg    <= vps_next;
            spv_reg    <= spv_next;
            iclamp_reg <= iclamp_next;
            dlimit_reg <= dlimit_next;
            aw_reg     <= aw_next;
            pos_reg    <= pos_next;
            prev_reg   <= prev_next;
            target_reg <= target_next;
            integ_reg  <= integ_next;
        end
    end

    // Working registers, loaded by operation
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                cnt_reg        <= s_tdata[COUNT_WIDTH-1:0];
                tv_reg         <= s_tdata[63:32];
                sd_reg         <= s_tdata[87:64];
                duty_res_reg   <= '0;
                active_res_reg <= 1'b0;
            end
            OP_TERM_LOAD:
            begin
                mag_reg <= src_mag;
                neg_reg <= src_val[MAG_W-1];
            end
            OP_MUL_LO:
            begin
                mul_reg <= mul_prod;
            end
            OP_MUL_HI:
            begin
                plo_reg <= mul_reg;
                mul_reg <= mul_prod;
            end
            OP_TERM_FIN:
            begin
                case (cmd.term)
                    TERM_TV: tterm_reg <= term_val;
                    TERM_KP: up_reg    <= term_val;
                    TERM_KI: ui_reg    <= term_val;
                    default: ud_reg    <= term_val;
                endcase
            end
            OP_ERR:
            begin
                e_reg <= target_reg[TERM_W-1:0] - {pos_reg[31:0], 16'd0};
            end
            OP_VEL_MUL:
            begin
                mul_reg <= mul_prod;
            end
            OP_VEL_DIFF:
            begin
                ed_reg <= ed_val;
            end
            OP_INTEG:
            begin
                pd_reg <= {up_reg[TERM_W-1], up_reg} + {ud_reg[TERM_W-1], ud_reg};
            end
            OP_SUM:
            begin
                duty_res_reg   <= duty_val;
                active_res_reg <= !stat.tv_small;
            end
            default:
            begin
                neg_reg <= neg_reg;
            end
        endcase
        if (cmd.out_load)
        begin
            out_reg <= {{(OUT_DATA_W-POS_W-1-DUTY_W){1'b0}}, pos_reg, active_res_reg,
                        duty_res_reg};
        end
    end

endmodule

`default_nettype wire

FILE: hdl/wheel_velocity_pid_controller.sv
// Top level of the wheel velocity PID controller: sequencer, datapath and checks.
//
//   Channel   Direction  Transfer            Contents
//   s_*       in         tvalid & tready     position report or control tick
//   m_*       out        tvalid & tready     duty, active flag, position
//   cfg_*     in         cfg_we high         gain and limit registers 0..7
//
// A position report or an idle tick passes through its own step and then the
// output step before the next s_tready; a PID tick first makes nine passes through
// the one shared 32x32 multiplier and the adders that follow it.
// The finished word sits in the output register; a stalled m_tready holds the
// block in its last step. Reset is asynchronous and needs no clearing pass.
`default_nettype none

`include "assert_macros.svh"

module wheel_velocity_pid_controller
    import wvpc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // position_count, target_velocity, step_delta
    input  logic                  s_tuser,   // opcode
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // duty, control_active, position_steps, pad
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    wvpc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (dp_cmd),
        .stat     (dp_stat)
    );

    wvpc_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .m_tdata   (m_tdata)
    );

    // One word in flight: no new word straight after acceptance
    `WV_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, s_tvalid && s_tready, !s_tready)
    // Load the output register only when it is empty or being drained
    `WV_ASSERT_IMPL(a_load_into_free_slot, clk, rst_n, dp_cmd.out_load, !m_tvalid || m_tready)
    // A new output word comes only from a load
    `WV_ASSERT_IMPL(a_valid_from_load, clk, rst_n, $rose(m_tvalid), $past(dp_cmd.out_load))

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking testbench for the wheel velocity PID controller: predicts every result word.
`default_nettype none

module tb_top;
    import wvpc_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 30;
    localparam int SWEEP_ITEMS    = 120;
    localparam int WRAP_ITEM_CAP  = 200;

    // Receiver stall patterns
    localparam int RX_ALWAYS  = 0;
    localparam int RX_COIN    = 1;
    localparam int RX_PATTERN = 2;
    localparam int RX_BURSTY  = 3;

    typedef enum int {
        SET_MODERATE,
        SET_MODERATE_NO_AW,
        SET_FULL_SCALE,
        SET_ZERO_LIMITS,
        SET_NO_INTEGRAL,
        SET_RANDOM
    } setting_kind_t;

    typedef struct {
        logic signed [DUTY_W-1:0] duty;
        logic                     active;
        logic [POS_W-1:0]         pos;
    } duty_word_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata = '0;   // position_count, target_velocity, step_delta
    logic                  s_tuser = 1'b0; // opcode
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;        // duty, control_active, position_steps, pad
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    // Controller model: registers
    logic [GAIN_W-1:0] gain_prop, gain_integ, gain_deriv, gain_vel_per_step, gain_steps_per_vel;
    longint            integ_lim, duty_lim;
    bit                antiwindup_on;

    // Controller model: state
    bit                model_count_pending;
    bit                model_loop_idle;
    logic [POS_W-1:0]  model_pos;
    logic [31:0]       model_prev_count;
    logic [TGT_W-1:0]  model_target_q;
    longint            model_integ;

    duty_word_t  expected_words[$];
    int unsigned mismatch_count;
    int unsigned words_checked;
    int unsigned sensors_sent, idle_ticks, pid_ticks, clipped_duties, settings_applied;

    // Sender burst state and a running hall count for plausible reports
    int unsigned burst_left;
    logic [31:0] drive_count;

    // Receiver stall state
    int unsigned ready_mode = RX_ALWAYS;
    int unsigned mode_cycles = 0;
    int unsigned stall_left = 0;
    int unsigned stuck_cycles = 0;

    wheel_velocity_pid_controller u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // (a * g) >> sh on the magnitude, saturated, sign restored
    function automatic longint scaled_product(input longint a, input logic [GAIN_W-1:0] g,
                                              input int sh);
        logic [63:0] mag;
        logic [95:0] full;
        logic [95:0] q;
        mag  = (a < 0) ? -a : a;
        full = {32'h0, mag} * {64'h0, g};
        q    = full >> sh;
        if (q > {49'h0, TERM_LIMIT})
            q = {49'h0, TERM_LIMIT};
        return (a < 0) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("[%0t] mismatch on %s at word %0d: got %0d, want %0d",
                 $time, what, words_checked, got, want);
        mismatch_count++;
    endtask

    // Advance the controller model by one accepted word and form its result
    task automatic predict_duty_word(input logic op, input logic [31:0] count,
                                     input logic [31:0] tv_bits, input logic [23:0] sd_bits,
                                     output duty_word_t r);
        logic [31:0]      delta;
        logic [TGT_W-1:0] pos_q;
        logic [TGT_W-1:0] gap_q;
        longint           tv, sd, err, p_term, d_term, i_sum, vel_err, u, lim_back;
        r.duty   = '0;
        r.active = 1'b0;
        if (op == OPC_SENSOR)
        begin
            sensors_sent++;
            if (model_count_pending)
            begin
                model_prev_count    = count;
                model_count_pending = 1'b0;
            end
            delta            = count - model_prev_count;
            model_pos        = model_pos + {{16{delta[31]}}, delta};
            model_prev_count = count;
        end
        else
        begin
            pos_q = {model_pos, 16'h0};
            if (model_loop_idle)
            begin
                idle_ticks++;
                if (!model_count_pending)
                    model_loop_idle = 1'b0;
                model_target_q = pos_q;
                model_integ    = 0;
            end
            else
            begin
                pid_ticks++;
                tv = longint'($signed(tv_bits));
                sd = longint'($signed(sd_bits));
                model_target_q = model_target_q
                               + 64'(scaled_product(tv, gain_steps_per_vel, SHIFT_TGT));
                gap_q = model_target_q - pos_q;
                err   = $signed({{16{gap_q[47]}}, gap_q[47:0]});
                model_target_q = pos_q + 64'(err);

                p_term = scaled_product(err, gain_prop, SHIFT_DUTY);
                i_sum  = model_integ + scaled_product(err, gain_integ, SHIFT_DUTY);
                if (i_sum > integ_lim)
                    i_sum = integ_lim;
                if (i_sum < -integ_lim)
                    i_sum = -integ_lim;
                model_integ = i_sum;

                vel_err = tv - sd * longint'({32'h0, gain_vel_per_step});
                d_term  = scaled_product(vel_err, gain_deriv, SHIFT_DUTY);
                u       = p_term + d_term + model_integ;

                // Back-calculate the integrator so the sum sits on the limit
                if (antiwindup_on)
                begin
                    if (u > duty_lim && model_integ > 0)
                    begin
                        lim_back    = duty_lim - p_term - d_term;
                        model_integ = (lim_back > 0) ? lim_back : 0;
                    end
                    else if (u < -duty_lim && model_integ < 0)
                    begin
                        lim_back    = -duty_lim - p_term - d_term;
                        model_integ = (lim_back < 0) ? lim_back : 0;
                    end
                end

                if (u > duty_lim || u < -duty_lim)
                    clipped_duties++;
                if (u > duty_lim)
                    u = duty_lim;
                if (u < -duty_lim)
                    u = -duty_lim;
                r.duty = u[DUTY_W-1:0];

                model_loop_idle = (tv >= -longint'(IDLE_VEL_RAW)) && (tv <= longint'(IDLE_VEL_RAW));
                r.active = !model_loop_idle;
            end
        end
        r.pos = model_pos;
    endtask

    // Send one input word, idling in bursts, and queue its expected result
    task automatic send_word(input logic op, input logic [31:0] count,
                             input logic [31:0] tv, input logic [23:0] sd);
        int unsigned gap;
        duty_word_t  r;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {sd, tv, count};
        do
            @(posedge clk);
        while (!s_tready);
        predict_duty_word(op, count, tv, sd, r);
        expected_words.push_back(r);
    endtask

    // Hold off the sender until every result is back and the block has settled
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_PROP_GAIN:     gain_prop          = val;
            REG_INTEG_GAIN:    gain_integ         = val;
            REG_DERIV_GAIN:    gain_deriv         = val;
            REG_VEL_PER_STEP:  gain_vel_per_step  = val;
            REG_STEPS_PER_VEL: gain_steps_per_vel = val;
            REG_INTEG_CLAMP:   integ_lim          = longint'(val[LIMIT_W-1:0]);
            REG_DUTY_LIMIT:    duty_lim           = longint'(val[LIMIT_W-1:0]);
            REG_ANTIWINDUP:    antiwindup_on      = val[0];
            default: ;
        endcase
    endtask

    // Write all eight registers once the block is idle
    task automatic apply_settings(input logic [31:0] kp, input logic [31:0] ki,
                                  input logic [31:0] kd, input logic [31:0] vps,
                                  input logic [31:0] spv, input logic [31:0] iclamp,
                                  input logic [31:0] dlim, input logic [31:0] aw);
        wait_until_drained();
        write_reg(REG_PROP_GAIN, kp);
        write_reg(REG_INTEG_GAIN, ki);
        write_reg(REG_DERIV_GAIN, kd);
        write_reg(REG_VEL_PER_STEP, vps);
        write_reg(REG_STEPS_PER_VEL, spv);
        write_reg(REG_INTEG_CLAMP, iclamp);
        write_reg(REG_DUTY_LIMIT, dlim);
        write_reg(REG_ANTIWINDUP, aw);
        cfg_we <= 1'b0;
        @(posedge clk);
        settings_applied++;
    endtask

    // Mostly plausible wheel motion with random content, some noise
    task automatic send_random_word();
        int unsigned pick;
        int          step;
        logic [31:0] tv;
        logic [23:0] sd;
        pick = $urandom_range(0, 99);
        if ($urandom_range(0, 1) == 0)
            sd = 24'(int'($urandom_range(0, 4000)) - 2000);
        else
            sd = 24'($urandom);
        if (pick < 40)
        begin
            step = $urandom_range(0, 99);
            if (step < 85)
                drive_count = drive_count + 32'(int'($urandom_range(0, 4000)) - 2000);
            else if (step < 95)
                drive_count = $urandom;
            else
                drive_count = 32'h8000_0000 + 32'(int'($urandom_range(0, 64)) - 32);
            send_word(OPC_SENSOR, drive_count, $urandom, sd);
        end
        else
        begin
            step = $urandom_range(0, 99);
            if (step < 72)
                tv = 32'(int'($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
            else if (step < 82)
                tv = 32'(int'($urandom_range(0, 12)) - 6);
            else if (step < 87)
                tv = ($urandom_range(0, 1) == 0) ? 32'sd7 : -32'sd7;
            else
                tv = $urandom;
            send_word(OPC_TICK, $urandom, tv, sd);
        end
        // Now and then let every result come back before going on
        if ($urandom_range(0, 79) == 0)
            wait_until_drained();
    endtask

    // Ticks before any count, first count seeding, count wrap both ways, zero gains
    task automatic test_power_on();
        send_word(OPC_TICK, 32'h0, 32'sd1000, 24'sd0);
        send_word(OPC_SENSOR, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 24'hFF_FFFF);
        send_word(OPC_SENSOR, 32'h0000_0010, 32'h0, 24'h0);
        send_word(OPC_SENSOR, 32'h8000_0010, 32'h0, 24'h0);
        send_word(OPC_SENSOR, 32'h0000_0010, 32'h0, 24'h0);
        send_word(OPC_TICK, 32'hFFFF_FFFF, 32'h0, 24'h0);
        send_word(OPC_TICK, 32'h0, 32'h7FFF_FFFF, 24'h7F_FFFF);
        drive_count = 32'h0000_0010;
    endtask

    // Velocity and step extremes, stop threshold on both sides and restart
    task automatic test_stop_and_restart();
        apply_settings(32'h0001_0000, 32'h0000_0100, 32'hFFFF_FFFF, 32'h0001_0000,
                       32'h0000_8000, 32'd20000, 32'd30000, 32'd1);
        send_word(OPC_TICK, 32'h0, 32'h8000_0000, 24'h80_0000);
        send_word(OPC_TICK, 32'h0, 32'sd6, 24'h7F_FFFF);
        send_word(OPC_TICK, 32'h0, 32'h0, 24'h0);
        send_word(OPC_TICK, 32'h0, -32'sd7, 24'h0);
        send_word(OPC_TICK, 32'h0, -32'sd6, 24'h0);
        send_word(OPC_TICK, 32'h0, 32'h0, 24'h0);
        send_word(OPC_TICK, 32'h0, 32'sd7, 24'h0);
    endtask

    // Drive the target far from the position so the step error wraps
    task automatic test_target_wrap();
        apply_settings(32'hFFFF_FFFF, 32'h0000_1000, 32'h0, 32'h0,
                       32'hFFFF_FFFF, 32'd50, 32'd100, 32'd1);
        repeat (3) send_word(OPC_TICK, 32'h0, 32'h7FFF_FFFF, 24'h0);
        send_word(OPC_TICK, 32'h0, 32'h8000_0000, 24'h0);
    endtask

    // Random words under a sequence of register settings, extremes included
    task automatic test_gain_sweep();
        setting_kind_t kind;
        for (int k = 0; k <= int'(SET_RANDOM); k++)
        begin
            kind = setting_kind_t'(k);
            case (kind)
                SET_MODERATE, SET_MODERATE_NO_AW:
                    apply_settings($urandom_range(0, 32'h0010_0000),
                                   $urandom_range(0, 32'h0000_4000),
                                   $urandom_range(0, 32'h0000_0400),
                                   $urandom_range(0, 32'h0004_0000),
                                   $urandom_range(0, 32'h0001_0000),
                                   $urandom_range(1000, 32767),
                                   $urandom_range(2000, 32767),
                                   (kind == SET_MODERATE) ? 32'd1 : 32'd0);
                SET_FULL_SCALE:
                    apply_settings('1, '1, '1, '1, '1, 32'd32767, 32'd32767, 32'd1);
                SET_ZERO_LIMITS:
                    apply_settings($urandom, $urandom, $urandom, $urandom,
                                   $urandom_range(0, 32'h0001_0000), 32'd0, 32'd0, 32'd1);
                SET_NO_INTEGRAL:
                    apply_settings($urandom_range(0, 32'h0010_0000), 32'd0,
                                   $urandom_range(0, 32'h0000_0400),
                                   $urandom_range(0, 32'h0004_0000),
                                   $urandom_range(0, 32'h0001_0000),
                                   32'd32767, $urandom_range(100, 32767), 32'd1);
                default:
                    apply_settings($urandom, $urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom);
            endcase
            repeat (SWEEP_ITEMS) send_random_word();
        end
    endtask

    // Step the position by the largest count step towards zero until its sign
    // flips, then four more, at most WRAP_ITEM_CAP words in all
    task automatic test_position_wrap();
        logic [POS_W-1:0] last_pos;
        logic [31:0]      count_step;
        int               after_wrap;
        int               sent;
        after_wrap  = -1;
        sent        = 0;
        drive_count = model_prev_count;
        count_step  = model_pos[POS_W-1] ? 32'h7FFF_FFFF : 32'h8000_0000;
        while (after_wrap != 0 && sent < WRAP_ITEM_CAP)
        begin
            last_pos    = model_pos;
            drive_count = drive_count + count_step;
            send_word(OPC_SENSOR, drive_count, 32'h0, 24'h0);
            sent++;
            if (after_wrap > 0)
                after_wrap--;
            else if (after_wrap < 0 && model_pos[POS_W-1] != last_pos[POS_W-1])
                after_wrap = 4;
        end
        // Check two ticks against the position past the sign change
        send_word(OPC_TICK, 32'h0, 32'sd100000, 24'sd3);
        send_word(OPC_TICK, 32'h0, 32'sd100000, 24'sd3);
    endtask

    // Receiver: switch between stall patterns every so often
    always @(posedge clk)
    begin
        if (mode_cycles == 0)
        begin
            ready_mode  <= $urandom_range(RX_ALWAYS, RX_BURSTY);
            mode_cycles <= $urandom_range(20, 120);
        end
        else
            mode_cycles <= mode_cycles - 1;
        case (ready_mode)
            RX_ALWAYS:  m_tready <= 1'b1;
            RX_COIN:    m_tready <= 1'($urandom_range(0, 1));
            RX_PATTERN: m_tready <= (mode_cycles % 4 == 0);
            default:
            begin
                if (stall_left == 0)
                begin
                    m_tready   <= ~m_tready;
                    stall_left <= m_tready ? $urandom_range(1, 16) : $urandom_range(0, 3);
                end
                else
                    stall_left <= stall_left - 1;
            end
        endcase
    end

    // Compare each accepted result word with the oldest expectation
    always @(posedge clk)
    begin
        duty_word_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_words.size() == 0)
                report_mismatch("unexpected word", longint'(m_tdata[64:0]), 0);
            else
            begin
                want = expected_words.pop_front();
                if (m_tdata[15:0] !== want.duty)
                    report_mismatch("duty", longint'($signed(m_tdata[15:0])),
                                    longint'(want.duty));
                if (m_tdata[16] !== want.active)
                    report_mismatch("control_active", longint'(m_tdata[16]),
                                    longint'(want.active));
                if (m_tdata[64:17] !== want.pos)
                    report_mismatch("position_steps", longint'($signed(m_tdata[64:17])),
                                    longint'($signed(want.pos)));
            end
            words_checked++;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("[%0t] no word moved for %0d cycles, %0d results outstanding",
                     $time, WATCHDOG_LIMIT, expected_words.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial
    begin
        gain_prop           = '0;
        gain_integ          = '0;
        gain_deriv          = '0;
        gain_vel_per_step   = '0;
        gain_steps_per_vel  = '0;
        integ_lim           = 32767;
        duty_lim            = 32767;
        antiwindup_on       = 1'b0;
        model_count_pending = 1'b1;
        model_loop_idle     = 1'b1;
        model_pos           = '0;
        model_prev_count    = '0;
        model_target_q      = '0;
        model_integ         = 0;
        burst_left          = 0;
        drive_count         = '0;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_power_on();
        test_stop_and_restart();
        test_target_wrap();
        test_gain_sweep();
        test_position_wrap();
        wait_until_drained();

        $display("Covered %0d position reports, %0d idle ticks and %0d PID ticks",
                 sensors_sent, idle_ticks, pid_ticks);
        $display("under %0d register settings; %0d duties clipped, %0d words checked",
                 settings_applied, clipped_duties, words_checked);
        if (mismatch_count == 0 && expected_words.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end

endmodule

`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/wvpc_pkg.sv
hdl/wvpc_ctrl.sv
hdl/wvpc_dp.sv
hdl/wheel_velocity_pid_controller.sv
sim/tb_top.sv
